/* sv/fhc_pkg.sv */
// fhc_pkg: shared constants, types and the colormap for the heatmap colorizer
// used by fhc_div, fhc_log2 and frame_heatmap_colorizer; no dependencies
package fhc_pkg;

    localparam int FRAME_SIDE_DEF        = 256;
    localparam int LOG_FRACTION_BITS_DEF = 16;

    localparam int PIX_W      = 32;
    localparam int IDX_W      = 16;
    localparam int INT_W      = 10;
    localparam int MSB_W      = 5;
    localparam int COLOR_W    = 8;
    localparam int CMD_W      = 2;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MEASURE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COLORIZE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOG    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RANGE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_OVERRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE    = 2'd2;

    typedef struct packed {
        logic             sat;
        logic [INT_W-1:0] quot;
    } t_div_res;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rgb;

    localparam t_rgb RGB_WHITE = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF};

    function automatic t_rgb colormap(input t_div_res res);
        t_rgb               c;
        logic [COLOR_W-1:0] lo;
        lo = res.quot[COLOR_W-1:0];
        c  = RGB_WHITE;
        if (res.sat) begin
            c.red   = '1;
            c.green = '0;
            c.blue  = '0;
        end else begin
            case (res.quot[INT_W-1:INT_W-2])
                2'd0: begin
                    if (res.quot != '0) begin
                        c.red   = '0;
                        c.green = lo;
                        c.blue  = '1;
                    end
                end
                2'd1: begin
                    c.red   = '0;
                    c.green = '1;
                    c.blue  = ~lo;
                end
                2'd2: begin
                    c.red   = lo;
                    c.green = '1;
                    c.blue  = '0;
                end
                default: begin
                    c.red   = '1;
                    c.green = ~lo;
                    c.blue  = '0;
                end
            endcase
        end
        return c;
    endfunction

endpackage

/* sv/frame_heatmap_colorizer.sv */
// frame_heatmap_colorizer: two-pass false-color renderer, top level
// depends on fhc_pkg, fhc_log2 and fhc_div
//
// usage: requests enter on i_in_valid/o_in_stall with i_cmd and i_pixel_value.
// clear and measure requests give no result; colorize requests give one result
// on o_out_valid/i_out_stall with color and output coordinates. registers are
// to be written through i_cfg_we/i_cfg_index/i_cfg_data only while the block
// is idle; the block itself does not enforce it.
// one request is worked on at a time; o_in_stall is high from the accept
// of a colorize request until its result moves into the output register,
// and the next request can be accepted in the cycle after.
// a colorize request in linear and range modes goes through the serial divider
// (one quotient bit per cycle), which stops early when the result saturates;
// log mode first adds two passes of the log unit (shift normalize, then one
// squaring per fraction bit); a scale error found at the accept skips both
// units and goes straight to the hold state.
// the output register lets the next request be accepted while a result
// waits; a stalled receiver holds the result and, once a second result is
// done, the input stalls too.
// reset clears statistics, pixel counter, registers and the output valid.
module frame_heatmap_colorizer #(
    parameter int FRAME_SIDE        = fhc_pkg::FRAME_SIDE_DEF,
    parameter int LOG_FRACTION_BITS = fhc_pkg::LOG_FRACTION_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [fhc_pkg::CMD_W-1:0]          i_cmd,
    input  logic [fhc_pkg::PIX_W-1:0]          i_pixel_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [fhc_pkg::COLOR_W-1:0]        o_red,
    output logic [fhc_pkg::COLOR_W-1:0]        o_green,
    output logic [fhc_pkg::COLOR_W-1:0]        o_blue,
    output logic [fhc_pkg::COLOR_W-1:0]        o_out_col,
    output logic [fhc_pkg::COLOR_W-1:0]        o_out_row,
    output logic                               o_scale_error,
    input  logic                               i_cfg_we,
    input  logic [fhc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fhc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int PW       = fhc_pkg::PIX_W;
    localparam int CW       = fhc_pkg::COLOR_W;
    localparam int LOG_W    = fhc_pkg::MSB_W + LOG_FRACTION_BITS;
    localparam int NUM_W    = (LOG_W > PW) ? LOG_W : PW;
    localparam int IDX_W    = fhc_pkg::IDX_W;
    localparam int TOTAL    = FRAME_SIDE * FRAME_SIDE;
    localparam int IDX_LAST = (TOTAL > 2**IDX_W) ? (2**IDX_W - 1) : (TOTAL - 1);
    localparam int ALONG_W  = $clog2(FRAME_SIDE);
    localparam int ACR_W    = $clog2(IDX_LAST / FRAME_SIDE + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOGM = 5'b00010,
        S_LOGP = 5'b00100,
        S_DIV  = 5'b01000,
        S_HOLD = 5'b10000
    } t_state;

    // control
    t_state                       r_state, n_state;
    logic [fhc_pkg::MODE_W-1:0]   r_scale_mode, n_scale_mode;
    logic [PW-1:0]                r_max_override, n_max_override;
    logic                         r_transpose, n_transpose;
    logic [PW-1:0]                r_frame_max, n_frame_max;
    logic [PW-1:0]                r_frame_min, n_frame_min;
    logic [IDX_W-1:0]             r_index, n_index;
    logic [ALONG_W-1:0]           r_along, n_along;
    logic [ACR_W-1:0]             r_across, n_across;
    logic                         r_log_start, n_log_start;
    logic                         r_div_start, n_div_start;
    logic                         r_out_valid, n_out_valid;

    // payload
    logic [PW-1:0]                r_pix, n_pix;
    logic [PW-1:0]                r_log_in, n_log_in;
    logic [LOG_W-1:0]             r_lden, n_lden;
    logic [NUM_W-1:0]             r_num, n_num;
    logic [NUM_W-1:0]             r_den, n_den;
    logic                         r_err, n_err;
    fhc_pkg::t_rgb                r_rgb, n_rgb;
    logic [CW-1:0]                r_col, n_col;
    logic [CW-1:0]                r_row, n_row;
    fhc_pkg::t_rgb                r_out_rgb, n_out_rgb;
    logic [CW-1:0]                r_out_col, n_out_col;
    logic [CW-1:0]                r_out_row, n_out_row;
    logic                         r_out_err, n_out_err;

    logic                         w_accept;
    logic                         w_out_free;
    logic [PW-1:0]                w_m;
    logic [PW-1:0]                w_range_num;
    logic [PW-1:0]                w_range_den;
    logic                         w_log_done;
    logic [LOG_W-1:0]             w_log;
    logic                         w_div_done;
    fhc_pkg::t_div_res            w_div_res;
    logic [ALONG_W-1:0]           w_flip;
    logic [31:0]                  w_flip32;
    logic [31:0]                  w_acr32;

    fhc_log2 #(
        .LOG_FRAC (LOG_FRACTION_BITS)
    ) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_log_start),
        .i_value (r_log_in),
        .o_done  (w_log_done),
        .o_log   (w_log)
    );

    fhc_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_res   (w_div_res)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_m         = (r_max_override != '0) ? r_max_override : r_frame_max;
    assign w_range_num = (i_pixel_value > r_frame_min) ? (i_pixel_value - r_frame_min) : '0;
    assign w_range_den = r_frame_max - r_frame_min;
    assign w_flip      = ALONG_W'(FRAME_SIDE - 1) - r_along;
    assign w_flip32    = 32'(w_flip);
    assign w_acr32     = 32'(r_across);

    always_comb begin
        n_state        = r_state;
        n_scale_mode   = r_scale_mode;
        n_max_override = r_max_override;
        n_transpose    = r_transpose;
        n_frame_max    = r_frame_max;
        n_frame_min    = r_frame_min;
        n_index        = r_index;
        n_along        = r_along;
        n_across       = r_across;
        n_log_start    = 1'b0;
        n_div_start    = 1'b0;
        n_out_valid    = r_out_valid;
        n_pix          = r_pix;
        n_log_in       = r_log_in;
        n_lden         = r_lden;
        n_num          = r_num;
        n_den          = r_den;
        n_err          = r_err;
        n_rgb          = r_rgb;
        n_col          = r_col;
        n_row          = r_row;
        n_out_rgb      = r_out_rgb;
        n_out_col      = r_out_col;
        n_out_row      = r_out_row;
        n_out_err      = r_out_err;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                fhc_pkg::REG_SCALE_MODE:   n_scale_mode   = i_cfg_data[fhc_pkg::MODE_W-1:0];
                fhc_pkg::REG_MAX_OVERRIDE: n_max_override = i_cfg_data[PW-1:0];
                fhc_pkg::REG_TRANSPOSE:    n_transpose    = i_cfg_data[0];
                default: ;
            endcase
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_cmd)
                        fhc_pkg::CMD_CLEAR: begin
                            n_frame_max = '0;
                            n_frame_min = '1;
                            n_index     = '0;
                            n_along     = '0;
                            n_across    = '0;
                        end
                        fhc_pkg::CMD_MEASURE: begin
                            if (i_pixel_value > r_frame_max) begin
                                n_frame_max = i_pixel_value;
                            end
                            if (i_pixel_value != '0 && i_pixel_value < r_frame_min) begin
                                n_frame_min = i_pixel_value;
                            end
                        end
                        fhc_pkg::CMD_COLORIZE: begin
                            if (r_transpose) begin
                                n_col = w_acr32[CW-1:0];
                                n_row = w_flip32[CW-1:0];
                            end else begin
                                n_col = w_flip32[CW-1:0];
                                n_row = w_acr32[CW-1:0];
                            end
                            if (r_index == IDX_W'(IDX_LAST)) begin
                                n_index  = '0;
                                n_along  = '0;
                                n_across = '0;
                            end else begin
                                n_index = r_index + 1'b1;
                                if (r_along == ALONG_W'(FRAME_SIDE - 1)) begin
                                    n_along  = '0;
                                    n_across = r_across + 1'b1;
                                end else begin
                                    n_along = r_along + 1'b1;
                                end
                            end
                            n_err   = 1'b1;
                            n_rgb   = fhc_pkg::RGB_WHITE;
                            n_state = S_HOLD;
                            if (r_frame_max != '0) begin
                                unique case (r_scale_mode)
                                    fhc_pkg::MODE_LINEAR: begin
                                        n_err       = 1'b0;
                                        n_num       = NUM_W'(i_pixel_value);
                                        n_den       = NUM_W'(w_m);
                                        n_div_start = 1'b1;
                                        n_state     = S_DIV;
                                    end
                                    fhc_pkg::MODE_LOG: begin
                                        n_err       = 1'b0;
                                        n_pix       = i_pixel_value;
                                        n_log_in    = w_m;
                                        n_log_start = 1'b1;
                                        n_state     = S_LOGM;
                                    end
                                    fhc_pkg::MODE_RANGE: begin
                                        if (r_frame_max > r_frame_min) begin
                                            n_err       = 1'b0;
                                            n_num       = NUM_W'(w_range_num);
                                            n_den       = NUM_W'(w_range_den);
                                            n_div_start = 1'b1;
                                            n_state     = S_DIV;
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LOGM: begin
                if (w_log_done) begin
                    n_lden = w_log;
                    if (w_log == '0) begin
                        // log of a max of one
                        n_err   = 1'b1;
                        n_rgb   = fhc_pkg::RGB_WHITE;
                        n_state = S_HOLD;
                    end else begin
                        n_log_in    = r_pix;
                        n_log_start = 1'b1;
                        n_state     = S_LOGP;
                    end
                end
            end
            S_LOGP: begin
                if (w_log_done) begin
                    n_num       = NUM_W'(w_log);
                    n_den       = NUM_W'(r_lden);
                    n_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_rgb   = fhc_pkg::colormap(w_div_res);
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_rgb   = r_rgb;
                    n_out_col   = r_col;
                    n_out_row   = r_row;
                    n_out_err   = r_err;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_scale_mode   <= '0;
            r_max_override <= '0;
            r_transpose    <= 1'b0;
            r_frame_max    <= '0;
            r_frame_min    <= '1;
            r_index        <= '0;
            r_along        <= '0;
            r_across       <= '0;
            r_log_start    <= 1'b0;
            r_div_start    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_scale_mode   <= n_scale_mode;
            r_max_override <= n_max_override;
            r_transpose    <= n_transpose;
            r_frame_max    <= n_frame_max;
            r_frame_min    <= n_frame_min;
            r_index        <= n_index;
            r_along        <= n_along;
            r_across       <= n_across;
            r_log_start    <= n_log_start;
            r_div_start    <= n_div_start;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix     <= n_pix;
        r_log_in  <= n_log_in;
        r_lden    <= n_lden;
        r_num     <= n_num;
        r_den     <= n_den;
        r_err     <= n_err;
        r_rgb     <= n_rgb;
        r_col     <= n_col;
        r_row     <= n_row;
        r_out_rgb <= n_out_rgb;
        r_out_col <= n_out_col;
        r_out_row <= n_out_row;
        r_out_err <= n_out_err;
    end

    assign o_out_valid   = r_out_valid;
    assign o_red         = r_out_rgb.red;
    assign o_green       = r_out_rgb.green;
    assign o_blue        = r_out_rgb.blue;
    assign o_out_col     = r_out_col;
    assign o_out_row     = r_out_row;
    assign o_scale_error = r_out_err;

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    a_log_done_in_log: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_log_done |-> (r_state == S_LOGM || r_state == S_LOGP))
        else $error("log unit finished outside a log state");

    a_min_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_max != '0 |-> r_frame_min <= r_frame_max)
        else $error("smallest nonzero value above frame max");

    a_along_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_along <= ALONG_W'(FRAME_SIDE - 1))
        else $error("pixel position beyond frame side");

endmodule

/* sv/fhc_div.sv */
// fhc_div: bit-serial restoring divider, floor(1023*num/den) with saturation at 1024
// one quotient bit per cycle; depends on fhc_pkg
module fhc_div #(
    parameter int NUM_W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_W-1:0]    i_num,
    input  logic [NUM_W-1:0]    i_den,
    output logic                o_done,
    output fhc_pkg::t_div_res   o_res
);

    localparam int REM_W = NUM_W + fhc_pkg::INT_W;
    localparam int CNT_W = $clog2(fhc_pkg::INT_W);

    typedef enum logic [2:0] {
        D_IDLE  = 3'b001,
        D_CHECK = 3'b010,
        D_STEP  = 3'b100
    } t_dstate;

    t_dstate                    r_state, n_state;
    logic [REM_W-1:0]           r_rem, n_rem;
    logic [REM_W-1:0]           r_dsh, n_dsh;
    logic [fhc_pkg::INT_W-1:0]  r_quot, n_quot;
    logic                       r_nz, n_nz;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic                       r_done, n_done;
    fhc_pkg::t_div_res          r_res, n_res;

    logic [REM_W:0]             w_diff;
    logic                       w_ge;
    logic [fhc_pkg::INT_W-1:0]  w_q_next;

    assign w_diff   = {1'b0, r_rem} - {1'b0, r_dsh};
    assign w_ge     = !w_diff[REM_W];
    assign w_q_next = {r_quot[fhc_pkg::INT_W-2:0], w_ge};

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_dsh   = r_dsh;
        n_quot  = r_quot;
        n_nz    = r_nz;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_res   = r_res;
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    // 1023*num as (num << 10) - num
                    n_rem   = {i_num, {fhc_pkg::INT_W{1'b0}}} - REM_W'(i_num);
                    n_dsh   = {i_den, {fhc_pkg::INT_W{1'b0}}};
                    n_nz    = (i_num != '0);
                    n_state = D_CHECK;
                end
            end
            D_CHECK: begin
                if (w_ge) begin
                    n_res.sat  = 1'b1;
                    n_res.quot = '0;
                    n_done     = 1'b1;
                    n_state    = D_IDLE;
                end else begin
                    n_dsh   = r_dsh >> 1;
                    n_quot  = '0;
                    n_cnt   = '0;
                    n_state = D_STEP;
                end
            end
            D_STEP: begin
                if (w_ge) begin
                    n_rem = w_diff[REM_W-1:0];
                end
                n_quot = w_q_next;
                n_dsh  = r_dsh >> 1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(fhc_pkg::INT_W - 1)) begin
                    n_res.sat = 1'b0;
                    // nonzero pixel that scales below one
                    if (w_q_next == '0 && r_nz) begin
                        n_res.quot = fhc_pkg::INT_W'(1);
                    end else begin
                        n_res.quot = w_q_next;
                    end
                    n_done  = 1'b1;
                    n_state = D_IDLE;
                end
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_quot <= n_quot;
        r_nz   <= n_nz;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

/* sv/fhc_log2.sv */
// fhc_log2: fixed-point log2 of a 32-bit value, msb in the integer part
// normalizes by shifting, then one fraction bit per squaring; depends on fhc_pkg
module fhc_log2 #(
    parameter int LOG_FRAC = fhc_pkg::LOG_FRACTION_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [fhc_pkg::PIX_W-1:0]             i_value,
    output logic                                  o_done,
    output logic [fhc_pkg::MSB_W+LOG_FRAC-1:0]    o_log
);

    localparam int CNT_W = $clog2(LOG_FRAC);
    localparam int PW    = fhc_pkg::PIX_W;

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_NORM = 3'b010,
        L_SQR  = 3'b100
    } t_lstate;

    t_lstate                     r_state, n_state;
    logic [PW-1:0]               r_x, n_x;
    logic [fhc_pkg::MSB_W-1:0]   r_msb, n_msb;
    logic [LOG_FRAC-1:0]         r_frac, n_frac;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic                        r_done, n_done;

    logic [2*PW-1:0]             w_sq;
    logic [PW-1:0]               w_x_sq;

    assign w_sq   = (2*PW)'(r_x) * (2*PW)'(r_x);
    assign w_x_sq = w_sq[2*PW-1] ? w_sq[2*PW-1:PW] : w_sq[2*PW-2:PW-1];

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_msb   = r_msb;
        n_frac  = r_frac;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        unique case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    n_x     = i_value;
                    n_msb   = fhc_pkg::MSB_W'(PW - 1);
                    n_state = L_NORM;
                end
            end
            L_NORM: begin
                if (r_x == '0) begin
                    n_msb   = '0;
                    n_frac  = '0;
                    n_done  = 1'b1;
                    n_state = L_IDLE;
                end else if (r_x[PW-1]) begin
                    n_frac  = '0;
                    n_cnt   = '0;
                    n_state = L_SQR;
                end else if (r_x[PW-1:PW-4] == '0) begin
                    n_x   = r_x << 4;
                    n_msb = r_msb - fhc_pkg::MSB_W'(4);
                end else begin
                    n_x   = r_x << 1;
                    n_msb = r_msb - 1'b1;
                end
            end
            L_SQR: begin
                n_x    = w_x_sq;
                n_frac = {r_frac[LOG_FRAC-2:0], w_sq[2*PW-1]};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(LOG_FRAC - 1)) begin
                    n_done  = 1'b1;
                    n_state = L_IDLE;
                end
            end
            default: begin
                n_state = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_msb  <= n_msb;
        r_frac <= n_frac;
        r_cnt  <= n_cnt;
    end

    assign o_done = r_done;
    assign o_log  = {r_msb, r_frac};

endmodule

/* verif/tb.sv */
// tb: self-checking testbench for frame_heatmap_colorizer, a directed table then random
// frames of clear, measure and colorize requests with random idling on both channels
// depends on fhc_pkg and frame_heatmap_colorizer; results checked against an own predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fhc_pkg::*;

    localparam logic [CMD_W-1:0]  CMD_UNUSED  = 2'd3;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int SIDE       = FRAME_SIDE_DEF;
    localparam int LOG_FB     = LOG_FRACTION_BITS_DEF;
    localparam int RAND_ITEMS = 1420;
    localparam int SETTLE     = 80;
    localparam int LIMIT      = 1_000_000;
    localparam int NDIR       = 37;
    localparam bit ROW_REQ    = 1'b0;
    localparam bit ROW_REG    = 1'b1;

    localparam t_rgb RGB_SAT  = '{red: 8'hFF, green: 8'h00, blue: 8'h00};
    localparam t_rgb RGB_LOW  = '{red: 8'h00, green: 8'h01, blue: 8'hFF};
    localparam t_rgb RGB_NONE = '{red: 8'h00, green: 8'h00, blue: 8'h00};

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] out_col;
        logic [COLOR_W-1:0] out_row;
        logic               scale_err;
    } t_pix_res;

    typedef struct packed {
        bit               kind;
        logic [1:0]       code;
        logic [PIX_W-1:0] val;
        bit               fixed;
        t_rgb             rgb;
        logic             scale_err;
    } t_dir_row;

    // typed colors only where the outcome is obvious
    localparam t_dir_row DIRECTED [0:NDIR-1] = '{
        '{ROW_REQ, CMD_COLORIZE, 32'd5,          1'b1, RGB_WHITE, 1'b1},
        '{ROW_REQ, CMD_UNUSED,   32'hFFFF_FFFF,  1'b0, RGB_NONE,  1'b0},
        '{ROW_REQ, CMD_MEASURE,  32'd0,          1'b0, RGB_NONE,  1'b0},
        '{ROW_REQ, CMD_MEASURE,  32'hFFFF_FFFF,  1'b0, RGB_NONE,  1'b0},
        '{ROW_REQ, CMD_COLORIZE, 32'hFFFF_FFFF,  1'b1, RGB_SAT,   1'b0},
        '{ROW_REQ, CMD_COLORIZE, 32'd0,          1'b1, RGB_WHITE, 1'b0},
        '{ROW_REQ, CMD_COLORIZE, 32'd1,          1'b1, RGB_LOW,   1'b0},
        '{ROW_REQ, CMD_COLORIZE, 32'h8000_0000,  1'b0, RGB_NONE,  1'b0},
        '{ROW_REQ, CMD_CLEAR,    32'd0,          1'b0, RGB_NONE,  1'b0},
        '{ROW_REQ, CMD_MEASURE,  32'd256,        1'b0, RGB_NONE,  1'b0},
        '{ROW_REQ, CMD_COLORIZE, 32'd512,        1'b1, RGB_SAT,   1'b0},
        '{ROW_REQ, CMD_COLORIZE, 32'd129,        1'b0, RGB_NONE,  1'b0},
        '{ROW_REG, REG_SCALE_MODE,   32'(MODE_UNUSED), 1'b0, RGB_NONE, 1'b0},
        '{ROW_REQ, CMD_COLORIZE, 32'd100,        1'b1, RGB_WHITE, 1'b1},
        '{ROW_REG, REG_SCALE_MODE,   32'(MODE_LOG),    1'b0, RGB_NONE, 1'b0},
        '{ROW_REQ, CMD_COLORIZE, 32'd1,          1'b1, RGB_WHITE, 1'b0},
        '{ROW_REQ, CMD_COLORIZE, 32'd256,        1'b1, RGB_SAT,   1'b0},
        '{ROW_REQ, CMD_COLORIZE, 32'd16,         1'b0, RGB_NONE,  1'b0},
        '{ROW_REG, REG_MAX_OVERRIDE, 32'd1,            1'b0, RGB_NONE, 1'b0},
        '{ROW_REQ, CMD_COLORIZE, 32'd7,          1'b1, RGB_WHITE, 1'b1},
        '{ROW_REG, REG_MAX_OVERRIDE, 32'hFFFF_FFFF,    1'b0, RGB_NONE, 1'b0},
        '{ROW_REQ, CMD_COLORIZE, 32'h0001_0000,  1'b0, RGB_NONE,  1'b0},
        '{ROW_REG, REG_MAX_OVERRIDE, 32'd0,            1'b0, RGB_NONE, 1'b0},
        '{ROW_REG, REG_SCALE_MODE,   32'(MODE_RANGE),  1'b0, RGB_NONE, 1'b0},
        '{ROW_REQ, CMD_CLEAR,    32'd0,          1'b0, RGB_NONE,  1'b0},
        '{ROW_REQ, CMD_MEASURE,  32'd50,         1'b0, RGB_NONE,  1'b0},
        '{ROW_REQ, CMD_COLORIZE, 32'd50,         1'b1, RGB_WHITE, 1'b1},
        '{ROW_REQ, CMD_MEASURE,  32'd10,         1'b0, RGB_NONE,  1'b0},
        '{ROW_REQ, CMD_COLORIZE, 32'd10,         1'b1, RGB_WHITE, 1'b0},
        '{ROW_REQ, CMD_COLORIZE, 32'd5,          1'b1, RGB_WHITE, 1'b0},
        '{ROW_REQ, CMD_COLORIZE, 32'd50,         1'b1, RGB_SAT,   1'b0},
        '{ROW_REQ, CMD_COLORIZE, 32'd11,         1'b0, RGB_NONE,  1'b0},
        '{ROW_REG, REG_TRANSPOSE,    32'd1,            1'b0, RGB_NONE, 1'b0},
        '{ROW_REQ, CMD_COLORIZE, 32'd30,         1'b0, RGB_NONE,  1'b0},
        '{ROW_REG, REG_SCALE_MODE,   32'(MODE_LINEAR), 1'b0, RGB_NONE, 1'b0},
        '{ROW_REG, REG_MAX_OVERRIDE, 32'd100,          1'b0, RGB_NONE, 1'b0},
        '{ROW_REQ, CMD_COLORIZE, 32'hFFFF_FFFF,  1'b1, RGB_SAT,   1'b0}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [CMD_W-1:0]      i_cmd;
    logic [PIX_W-1:0]      i_pixel_value;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [COLOR_W-1:0]    o_red;
    logic [COLOR_W-1:0]    o_green;
    logic [COLOR_W-1:0]    o_blue;
    logic [COLOR_W-1:0]    o_out_col;
    logic [COLOR_W-1:0]    o_out_row;
    logic                  o_scale_error;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    frame_heatmap_colorizer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_pixel_value (i_pixel_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_out_col     (o_out_col),
        .o_out_row     (o_out_row),
        .o_scale_error (o_scale_error),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // predicted block state and registers
    logic [PIX_W-1:0]  fm_max     = '0;
    logic [PIX_W-1:0]  fm_min_nz  = '1;
    logic [IDX_W-1:0]  pix_idx    = '0;
    logic [MODE_W-1:0] cfg_mode   = MODE_LINEAR;
    logic [PIX_W-1:0]  cfg_max_ovr = '0;
    logic              cfg_transpose = 1'b0;

    t_pix_res px_colors_due[$];
    int       mismatches = 0;
    int       n_sent     = 0;
    int       stall_left = 0;
    int       cycles     = 0;
    bit       no_idle    = 1'b0;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic int pick_gap();
        return no_idle ? 0 : $urandom_range(10, 0);
    endfunction

    function automatic logic [63:0] log2_fixed(input logic [PIX_W-1:0] v);
        int          msb;
        logic [63:0] x;
        logic [63:0] frac;
        msb  = 0;
        frac = '0;
        if (v == '0) begin
            return '0;
        end
        for (int b = 0; b < PIX_W; b++) begin
            if (v[b]) begin
                msb = b;
            end
        end
        x = 64'(v) << (31 - msb);
        for (int k = 0; k < LOG_FB; k++) begin
            x    = (x * x) >> 31;
            frac = frac << 1;
            if (x >= 64'h1_0000_0000) begin
                frac[0] = 1'b1;
                x       = x >> 1;
            end
        end
        return (64'(msb) << LOG_FB) | frac;
    endfunction

    function automatic t_rgb heat_color(input logic [63:0] lvl);
        t_rgb c;
        if (lvl == 0) begin
            c = RGB_WHITE;
        end else if (lvl < 256) begin
            c = '{red: 8'd0, green: lvl[7:0], blue: 8'd255};
        end else if (lvl < 512) begin
            c = '{red: 8'd0, green: 8'd255, blue: 8'(511 - lvl)};
        end else if (lvl < 768) begin
            c = '{red: 8'(lvl - 512), green: 8'd255, blue: 8'd0};
        end else if (lvl < 1024) begin
            c = '{red: 8'd255, green: 8'(1023 - lvl), blue: 8'd0};
        end else begin
            c = RGB_SAT;
        end
        return c;
    endfunction

    // advances the predicted state; returns 1 when a colored pixel comes out
    function automatic bit frame_step(input logic [CMD_W-1:0] cmd, input logic [PIX_W-1:0] p,
                                      output t_pix_res res);
        logic [63:0]      num;
        logic [63:0]      den;
        logic [63:0]      lvl;
        logic [PIX_W-1:0] m;
        bit               err;
        int unsigned      along;
        int unsigned      across;
        t_rgb             c;
        num = '0;
        den = 64'd1;
        lvl = '0;
        err = 1'b0;
        res = '0;
        case (cmd)
            CMD_CLEAR: begin
                fm_max    = '0;
                fm_min_nz = '1;
                pix_idx   = '0;
                return 1'b0;
            end
            CMD_MEASURE: begin
                if (p > fm_max) begin
                    fm_max = p;
                end
                if (p != '0 && p < fm_min_nz) begin
                    fm_min_nz = p;
                end
                return 1'b0;
            end
            CMD_COLORIZE: begin
            end
            default: begin
                return 1'b0;
            end
        endcase
        m = (cfg_max_ovr != '0) ? cfg_max_ovr : fm_max;
        if (fm_max == '0 || cfg_mode == MODE_UNUSED) begin
            err = 1'b1;
        end else if (cfg_mode == MODE_LINEAR) begin
            num = 64'(p);
            den = 64'(m);
        end else if (cfg_mode == MODE_LOG) begin
            num = log2_fixed(p);
            den = log2_fixed(m);
            err = (den == '0);
        end else if (fm_max <= fm_min_nz) begin
            err = 1'b1;
        end else begin
            num = (p > fm_min_nz) ? 64'(p - fm_min_nz) : 64'd0;
            den = 64'(fm_max - fm_min_nz);
        end
        if (!err) begin
            lvl = (num * 64'd1023) / den;
            if (lvl == 0 && num != 0) begin
                lvl = 64'd1;
            end
        end
        c      = err ? RGB_WHITE : heat_color(lvl);
        along  = pix_idx % SIDE;
        across = pix_idx / SIDE;
        res.red       = c.red;
        res.green     = c.green;
        res.blue      = c.blue;
        res.out_col   = cfg_transpose ? 8'(across) : 8'(SIDE - 1 - along);
        res.out_row   = cfg_transpose ? 8'(SIDE - 1 - along) : 8'(across);
        res.scale_err = err;
        pix_idx = pix_idx + 1'b1;
        if (32'(pix_idx) >= SIDE * SIDE) begin
            pix_idx = '0;
        end
        return 1'b1;
    endfunction

    task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t %s expected %0d got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : chk_out
        t_pix_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (px_colors_due.size() == 0) begin
                $display("%0t unexpected result r %0d g %0d b %0d col %0d row %0d err %0d",
                         $time, o_red, o_green, o_blue, o_out_col, o_out_row, o_scale_error);
                mismatches++;
            end else begin
                want = px_colors_due.pop_front();
                cmp_field("red", want.red, o_red);
                cmp_field("green", want.green, o_green);
                cmp_field("blue", want.blue, o_blue);
                cmp_field("out_col", want.out_col, o_out_col);
                cmp_field("out_row", want.out_row, o_out_row);
                cmp_field("scale_error", 8'(want.scale_err), 8'(o_scale_error));
            end
            stall_left = pick_gap();
        end
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_stall = 1'b1;
                stall_left--;
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    initial begin
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb NOT OK");
        $finish;
    end

    // entered and left at a falling edge; valid stays high for a back-to-back request
    task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [PIX_W-1:0] pix,
                            input bit fixed, input t_rgb rgb, input logic err);
        int       gap;
        t_pix_res res;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_cmd         = cmd;
        i_pixel_value = pix;
        do @(posedge i_clk); while (o_in_stall);
        if (frame_step(cmd, pix, res)) begin
            if (fixed) begin
                res.red       = rgb.red;
                res.green     = rgb.green;
                res.blue      = rgb.blue;
                res.scale_err = err;
            end
            px_colors_due.push_back(res);
        end
        if (cmd != CMD_UNUSED) begin
            n_sent++;
        end
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (px_colors_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        case (idx)
            REG_SCALE_MODE:   cfg_mode      = val[MODE_W-1:0];
            REG_MAX_OVERRIDE: cfg_max_ovr   = val;
            REG_TRANSPOSE:    cfg_transpose = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] any_pixel();
        case ($urandom_range(9, 0))
            0, 1, 2, 3: return $urandom;
            4, 5:       return $urandom >> $urandom_range(31, 0);
            6:          return $urandom_range(15, 0);
            7:          return '0;
            8:          return '1;
            default:    return $urandom_range(5000, 1000);
        endcase
    endfunction

    // mostly pixels inside the measured range so the whole colormap gets used
    function automatic logic [PIX_W-1:0] frame_pixel();
        int unsigned k;
        k = $urandom_range(9, 0);
        if (k < 6 && fm_max != '0) begin
            if (k < 2 && fm_min_nz <= fm_max) begin
                return $urandom_range(fm_max, fm_min_nz);
            end
            return $urandom_range(fm_max, 0);
        end
        return any_pixel();
    endfunction

    task automatic pick_config();
        int unsigned k;
        k = $urandom_range(9, 0);
        write_reg(REG_SCALE_MODE, (k == 9) ? 32'(MODE_UNUSED) : 32'(k % 3));
        if ($urandom_range(1, 0) == 1) begin
            case ($urandom_range(5, 0))
                0:       write_reg(REG_MAX_OVERRIDE, 32'd1);
                1:       write_reg(REG_MAX_OVERRIDE, '1);
                2:       write_reg(REG_MAX_OVERRIDE, $urandom);
                3:       write_reg(REG_MAX_OVERRIDE, $urandom_range(65535, 2));
                default: write_reg(REG_MAX_OVERRIDE, '0);
            endcase
        end
        if ($urandom_range(2, 0) == 0) begin
            write_reg(REG_TRANSPOSE, 32'($urandom_range(1, 0)));
        end
    endtask

    initial begin : main
        int n_meas;
        int n_col;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_cmd         = CMD_CLEAR;
        i_pixel_value = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_SCALE_MODE;
        i_cfg_data    = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < NDIR; i++) begin
            if (DIRECTED[i].kind == ROW_REG) begin
                write_reg(DIRECTED[i].code, DIRECTED[i].val);
            end else begin
                send_req(DIRECTED[i].code, DIRECTED[i].val, DIRECTED[i].fixed,
                         DIRECTED[i].rgb, DIRECTED[i].scale_err);
            end
        end

        n_sent = 0;
        while (n_sent < RAND_ITEMS) begin
            no_idle = ($urandom_range(3, 0) == 0);
            if ($urandom_range(2, 0) == 0) begin
                pick_config();
            end
            if ($urandom_range(1, 0) == 1) begin
                send_req(CMD_CLEAR, $urandom, 1'b0, RGB_NONE, 1'b0);
            end
            n_meas = $urandom_range(16, 1);
            for (int j = 0; j < n_meas; j++) begin
                if ($urandom_range(19, 0) == 0) begin
                    send_req(CMD_UNUSED, $urandom, 1'b0, RGB_NONE, 1'b0);
                end
                send_req(CMD_MEASURE, any_pixel(), 1'b0, RGB_NONE, 1'b0);
            end
            n_col = $urandom_range(40, 4);
            for (int j = 0; j < n_col; j++) begin
                case ($urandom_range(24, 0))
                    0:       send_req(CMD_UNUSED, $urandom, 1'b0, RGB_NONE, 1'b0);
                    1:       send_req(CMD_MEASURE, any_pixel(), 1'b0, RGB_NONE, 1'b0);
                    default: ;
                endcase
                send_req(CMD_COLORIZE, frame_pixel(), 1'b0, RGB_NONE, 1'b0);
            end
            if ($urandom_range(7, 0) == 0) begin
                drain();
            end
        end

        drain();
        repeat (SETTLE) @(negedge i_clk);
        if (mismatches == 0 && px_colors_due.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
